// ===== sv/whp_pkg.sv =====
// Shared types and constants of the RIFF/WAVE header parser.
package whp_pkg;

  localparam int unsigned RES_W = 144;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] MIN_STREAM = 32'd44;
  localparam logic [31:0] FMT_SHORT  = 32'd16;
  localparam logic [31:0] FMT_LONG   = 32'd18;
  localparam logic [4:0]  FMT_END_SHORT = 5'd15;
  localparam logic [4:0]  FMT_END_LONG  = 5'd17;

  localparam logic [15:0] MODE_PCM   = 16'd1;
  localparam logic [15:0] MODE_FLOAT = 16'd3;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_FMT   = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_NOT_RIFF  = 4'd1;
  localparam logic [3:0] ST_NOT_WAVE  = 4'd2;
  localparam logic [3:0] ST_FMT_SIZE  = 4'd3;
  localparam logic [3:0] ST_MODE      = 4'd4;
  localparam logic [3:0] ST_EXT       = 4'd5;
  localparam logic [3:0] ST_CHANNELS  = 4'd6;
  localparam logic [3:0] ST_BITS      = 4'd7;
  localparam logic [3:0] ST_ALIGN24   = 4'd8;
  localparam logic [3:0] ST_NO_DATA   = 4'd9;
  localparam logic [3:0] ST_SHORT     = 4'd10;
  localparam logic [3:0] ST_ZERO_ALGN = 4'd11;

  localparam logic [2:0] IF_U8  = 3'd0;
  localparam logic [2:0] IF_S16 = 3'd1;
  localparam logic [2:0] IF_S24 = 3'd2;
  localparam logic [2:0] IF_S32 = 3'd3;
  localparam logic [2:0] IF_F32 = 3'd4;
  localparam logic [2:0] IF_F64 = 3'd5;

  localparam logic [1:0] OF_U8  = 2'd0;
  localparam logic [1:0] OF_S16 = 2'd1;
  localparam logic [1:0] OF_S32 = 2'd2;
  localparam logic [1:0] OF_F32 = 2'd3;

  typedef enum logic [3:0] {
    PH_RIFF,
    PH_RSIZE,
    PH_WAVE,
    PH_CID,
    PH_CSIZE,
    PH_FMT,
    PH_SKIP,
    PH_HOLD,
    PH_DIV
  } phase_t;

endpackage

// ===== sv/wav_header_parser.sv =====
// Top level of the RIFF/WAVE header parser: byte walker, format check and result register.
//
// The parser takes one file byte per cycle while in_tready is high. When the data chunk
// header completes with a nonzero block alignment, the frame count is formed by a serial
// divider that produces one quotient bit per cycle, and in_tready stays low until the
// quotient is ready. The single result waits in an output register, and input is also held
// off while that register is full and not being taken.
module wav_header_parser
  import whp_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,   // byte_value
  input  logic           in_tlast,   // last_byte
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [RES_W-1:0] out_tdata // status, channel_count, rate_hz, in_format,
                                     // out_format, riff_size, data_offset, frame_count
);

  phase_t      phase_r, phase_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [23:0] shift_r, shift_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] left_r, left_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [15:0] mode_r, mode_nxt;
  logic [15:0] ch_r, ch_nxt;
  logic [30:0] rate_r, rate_nxt;
  logic [15:0] align_r, align_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] riff_r, riff_nxt;
  logic        verdict_r, verdict_nxt;
  logic [4:0]  fpos_r, fpos_nxt;
  logic        flong_r, flong_nxt;
  logic        extnz_r, extnz_nxt;
  logic        hvalid_r, hvalid_nxt;
  logic [3:0]  hstatus_r, hstatus_nxt;
  logic [31:0] hoffset_r, hoffset_nxt;
  logic [31:0] hframes_r, hframes_nxt;
  logic        plast_r, plast_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [RES_W-1:0] out_data_r, out_data_nxt;

  logic        in_acc;
  logic [31:0] word;
  logic        div_start;
  logic        div_done;
  logic [31:0] div_quo;
  logic        emit_en;
  logic [3:0]  emit_status;
  logic        do_reset;
  logic [3:0]  fmt_st;
  logic [2:0]  ok_if;
  logic [1:0]  ok_of;
  logic [31:0] ok_frames;

  function automatic logic [3:0] check_fmt(input logic [15:0] mode, input logic [15:0] ch,
                                           input logic [15:0] bits, input logic [15:0] align,
                                           input logic ext_nz);
    logic [3:0] st;
    st = ST_OK;
    if (mode != MODE_PCM && mode != MODE_FLOAT) st = ST_MODE;
    else if (ext_nz) st = ST_EXT;
    else if (ch != 16'd1 && ch != 16'd2) st = ST_CHANNELS;
    else if (bits != 16'd8 && bits != 16'd16 && bits != 16'd24 && bits != 16'd32
             && bits != 16'd64) st = ST_BITS;
    else if (bits == 16'd24 && align != ((ch == 16'd1) ? 16'd3 : 16'd6)) st = ST_ALIGN24;
    return st;
  endfunction

  whp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (word),
    .divisor  (align_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_acc = in_tvalid && in_tready;
  assign word   = {in_tdata, shift_r};

  always_comb begin
    ok_if = IF_S32;
    ok_of = OF_S32;
    if (mode_r == MODE_FLOAT) begin
      ok_if = (bits_r == 16'd32) ? IF_F32 : IF_F64;
      ok_of = OF_F32;
    end else if (bits_r == 16'd24) begin
      ok_if = IF_S24;
      ok_of = OF_S16;
    end else if (bits_r == 16'd8) begin
      ok_if = IF_U8;
      ok_of = OF_U8;
    end else if (bits_r == 16'd16) begin
      ok_if = IF_S16;
      ok_of = OF_S16;
    end
    ok_frames = (phase_r == PH_DIV) ? div_quo : hframes_r;
  end

  always_comb begin
    phase_nxt   = phase_r;
    offset_nxt  = offset_r;
    shift_nxt   = shift_r;
    idx_nxt     = idx_r;
    left_nxt    = left_r;
    kind_nxt    = kind_r;
    mode_nxt    = mode_r;
    ch_nxt      = ch_r;
    rate_nxt    = rate_r;
    align_nxt   = align_r;
    bits_nxt    = bits_r;
    riff_nxt    = riff_r;
    verdict_nxt = verdict_r;
    fpos_nxt    = fpos_r;
    flong_nxt   = flong_r;
    extnz_nxt   = extnz_r;
    hvalid_nxt  = hvalid_r;
    hstatus_nxt = hstatus_r;
    hoffset_nxt = hoffset_r;
    hframes_nxt = hframes_r;
    plast_nxt   = plast_r;
    div_start   = 1'b0;
    emit_en     = 1'b0;
    emit_status = ST_OK;
    do_reset    = 1'b0;
    fmt_st      = ST_OK;

    if (in_acc) begin
      if (offset_r != '1) offset_nxt = offset_r + 32'd1;
      if (!verdict_r) begin
        unique case (phase_r) inside
          PH_FMT: begin
            case (fpos_r) inside
              5'd0:  mode_nxt[7:0]    = in_tdata;
              5'd1:  mode_nxt[15:8]   = in_tdata;
              5'd2:  ch_nxt[7:0]      = in_tdata;
              5'd3:  ch_nxt[15:8]     = in_tdata;
              5'd4:  rate_nxt[7:0]    = in_tdata;
              5'd5:  rate_nxt[15:8]   = in_tdata;
              5'd6:  rate_nxt[23:16]  = in_tdata;
              5'd7:  rate_nxt[30:24]  = in_tdata[6:0];
              5'd12: align_nxt[7:0]   = in_tdata;
              5'd13: align_nxt[15:8]  = in_tdata;
              5'd14: bits_nxt[7:0]    = in_tdata;
              5'd15: bits_nxt[15:8]   = in_tdata;
              5'd16, 5'd17: extnz_nxt = extnz_r | (in_tdata != 8'd0);
              default: ;
            endcase
            fpos_nxt = fpos_r + 5'd1;
            if ((fpos_r == FMT_END_SHORT && !flong_r) || fpos_r == FMT_END_LONG) begin
              fmt_st = check_fmt(mode_nxt, ch_nxt, bits_nxt, align_nxt, extnz_nxt);
              if (fmt_st != ST_OK) begin
                hvalid_nxt  = 1'b1;
                hstatus_nxt = fmt_st;
                hoffset_nxt = '0;
                hframes_nxt = '0;
                phase_nxt   = PH_HOLD;
              end else begin
                phase_nxt = PH_CID;
                idx_nxt   = '0;
              end
            end
          end
          PH_SKIP: begin
            left_nxt = left_r - 32'd1;
            if (left_r == 32'd1) phase_nxt = PH_CID;
          end
          PH_HOLD, PH_DIV: ;
          PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_CSIZE: begin
            if (idx_r != 2'd3) begin
              idx_nxt   = idx_r + 2'd1;
              shift_nxt = {in_tdata, shift_r[23:8]};
            end else begin
              idx_nxt = '0;
              unique case (phase_r)
                PH_RIFF: begin
                  if (word != TAG_RIFF) begin
                    hvalid_nxt  = 1'b1;
                    hstatus_nxt = ST_NOT_RIFF;
                    hoffset_nxt = '0;
                    hframes_nxt = '0;
                    phase_nxt   = PH_HOLD;
                  end else begin
                    phase_nxt = PH_RSIZE;
                  end
                end
                PH_RSIZE: begin
                  riff_nxt  = word;
                  phase_nxt = PH_WAVE;
                end
                PH_WAVE: begin
                  if (word != TAG_WAVE) begin
                    hvalid_nxt  = 1'b1;
                    hstatus_nxt = ST_NOT_WAVE;
                    hoffset_nxt = '0;
                    hframes_nxt = '0;
                    phase_nxt   = PH_HOLD;
                  end else begin
                    phase_nxt = PH_CID;
                  end
                end
                PH_CID: begin
                  kind_nxt  = (word == TAG_FMT) ? KIND_FMT :
                              ((word == TAG_DATA) ? KIND_DATA : KIND_OTHER);
                  phase_nxt = PH_CSIZE;
                end
                default: begin
                  if (kind_r == KIND_FMT) begin
                    if (word != FMT_SHORT && word != FMT_LONG) begin
                      hvalid_nxt  = 1'b1;
                      hstatus_nxt = ST_FMT_SIZE;
                      hoffset_nxt = '0;
                      hframes_nxt = '0;
                      phase_nxt   = PH_HOLD;
                    end else begin
                      flong_nxt = (word == FMT_LONG);
                      fpos_nxt  = '0;
                      extnz_nxt = 1'b0;
                      phase_nxt = PH_FMT;
                    end
                  end else if (kind_r == KIND_DATA) begin
                    if (align_r == 16'd0) begin
                      hvalid_nxt  = 1'b1;
                      hstatus_nxt = ST_ZERO_ALGN;
                      hoffset_nxt = '0;
                      hframes_nxt = '0;
                      phase_nxt   = PH_HOLD;
                    end else begin
                      hoffset_nxt = offset_nxt;
                      plast_nxt   = in_tlast;
                      div_start   = 1'b1;
                      phase_nxt   = PH_DIV;
                    end
                  end else begin
                    left_nxt  = word;
                    phase_nxt = (word != 32'd0) ? PH_SKIP : PH_CID;
                  end
                end
              endcase
            end
          end
          default: ;
        endcase

        if (!div_start) begin
          if (hvalid_nxt && offset_nxt >= MIN_STREAM) begin
            emit_en     = 1'b1;
            emit_status = hstatus_nxt;
            verdict_nxt = 1'b1;
          end else if (in_tlast) begin
            emit_en     = 1'b1;
            emit_status = (offset_nxt < MIN_STREAM) ? ST_SHORT : ST_NO_DATA;
          end
        end
      end
      if (in_tlast && !div_start) do_reset = 1'b1;
    end else if (phase_r == PH_DIV && div_done) begin
      hvalid_nxt  = 1'b1;
      hstatus_nxt = ST_OK;
      hframes_nxt = div_quo;
      phase_nxt   = PH_HOLD;
      if (offset_r >= MIN_STREAM) begin
        emit_en     = 1'b1;
        emit_status = ST_OK;
        verdict_nxt = 1'b1;
      end else if (plast_r) begin
        emit_en     = 1'b1;
        emit_status = ST_SHORT;
      end
      if (plast_r) do_reset = 1'b1;
    end

    if (do_reset) begin
      phase_nxt   = PH_RIFF;
      offset_nxt  = '0;
      shift_nxt   = '0;
      idx_nxt     = '0;
      left_nxt    = '0;
      kind_nxt    = KIND_OTHER;
      mode_nxt    = '0;
      ch_nxt      = '0;
      rate_nxt    = '0;
      align_nxt   = '0;
      bits_nxt    = '0;
      riff_nxt    = '0;
      verdict_nxt = 1'b0;
      fpos_nxt    = '0;
      flong_nxt   = 1'b0;
      extnz_nxt   = 1'b0;
      hvalid_nxt  = 1'b0;
      hstatus_nxt = ST_OK;
      hoffset_nxt = '0;
      hframes_nxt = '0;
      plast_nxt   = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit_en) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt[3:0] = emit_status;
      if (emit_status == ST_OK) begin
        out_data_nxt[5:4]     = ch_r[1:0];
        out_data_nxt[36:6]    = rate_r;
        out_data_nxt[39:37]   = ok_if;
        out_data_nxt[41:40]   = ok_of;
        out_data_nxt[73:42]   = riff_r;
        out_data_nxt[105:74]  = hoffset_r;
        out_data_nxt[137:106] = ok_frames;
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_RIFF;
      offset_r    <= '0;
      shift_r     <= '0;
      idx_r       <= '0;
      left_r      <= '0;
      kind_r      <= KIND_OTHER;
      mode_r      <= '0;
      ch_r        <= '0;
      rate_r      <= '0;
      align_r     <= '0;
      bits_r      <= '0;
      riff_r      <= '0;
      verdict_r   <= 1'b0;
      fpos_r      <= '0;
      flong_r     <= 1'b0;
      extnz_r     <= 1'b0;
      hvalid_r    <= 1'b0;
      hstatus_r   <= ST_OK;
      hoffset_r   <= '0;
      hframes_r   <= '0;
      plast_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      offset_r    <= offset_nxt;
      shift_r     <= shift_nxt;
      idx_r       <= idx_nxt;
      left_r      <= left_nxt;
      kind_r      <= kind_nxt;
      mode_r      <= mode_nxt;
      ch_r        <= ch_nxt;
      rate_r      <= rate_nxt;
      align_r     <= align_nxt;
      bits_r      <= bits_nxt;
      riff_r      <= riff_nxt;
      verdict_r   <= verdict_nxt;
      fpos_r      <= fpos_nxt;
      flong_r     <= flong_nxt;
      extnz_r     <= extnz_nxt;
      hvalid_r    <= hvalid_nxt;
      hstatus_r   <= hstatus_nxt;
      hoffset_r   <= hoffset_nxt;
      hframes_r   <= hframes_nxt;
      plast_r     <= plast_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (phase_r != PH_DIV) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_div_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DIV |-> !in_tready)
    else $error("input accepted while the frame count is being divided");

  a_div_done_room: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> phase_r == PH_DIV && !out_valid_r)
    else $error("divider finished with no room for the result");

  a_verdict_held: assert property (@(posedge clk) disable iff (!rst_n)
    verdict_r |-> hvalid_r && phase_r == PH_HOLD)
    else $error("verdict delivered without a settled status");

endmodule

// ===== sv/whp_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
module whp_div
  import whp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [15:0] dsr_r, dsr_nxt;
  logic [16:0] trial;
  logic [16:0] diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r, quo_r[31]};
    diff     = trial - {1'b0, dsr_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = diff[15:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial[15:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == '1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start && cnt_r == '1 |=> done_r && !busy_r)
    else $error("divider did not finish after its last step");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider reports done while still busy");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench of the RIFF/WAVE header parser: random and directed byte streams.
`timescale 1ns / 100ps

module tb_top;
  import whp_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int RANDOM_BYTES = 870;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [5:0]  pad;
    logic [31:0] frame_count;
    logic [31:0] data_offset;
    logic [31:0] riff_size;
    logic [1:0]  out_format;
    logic [2:0]  in_format;
    logic [30:0] rate_hz;
    logic [1:0]  channel_count;
    logic [3:0]  status;
  } wav_verdict_t;

  typedef struct {
    logic [31:0] riff_tag;
    logic [31:0] riff_size;
    logic [31:0] wave_tag;
    bit          has_lead;
    logic [31:0] lead_len;
    bit          has_fmt;
    bit          fmt_twice;
    logic [31:0] fmt_len;
    logic [15:0] mode;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] align;
    logic [15:0] bits;
    logic [15:0] ext;
    bit          has_data;
    logic [31:0] data_len;
    int          payload;
    int          cut;
  } wav_spec_t;

  class wav_verdict_tracker;
    phase_t       phase;
    logic [31:0]  seen;
    logic [31:0]  word;
    logic [2:0]   word_idx;
    logic [31:0]  skip_left;
    logic [1:0]   kind;
    logic [15:0]  mode;
    logic [15:0]  chans;
    logic [15:0]  align;
    logic [15:0]  bits;
    logic [15:0]  ext;
    logic [31:0]  rate;
    logic [31:0]  riff_sz;
    logic         given;
    logic [7:0]   fmt_len;
    logic [7:0]   fmt_idx;
    logic         held;
    logic [3:0]   held_st;
    logic [31:0]  held_off;
    logic [31:0]  held_frames;
    wav_verdict_t verdicts_due[$];
    int           errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase = PH_RIFF;
      seen = '0;
      word = '0;
      word_idx = '0;
      skip_left = '0;
      kind = KIND_OTHER;
      mode = '0;
      chans = '0;
      align = '0;
      bits = '0;
      ext = '0;
      rate = '0;
      riff_sz = '0;
      given = 1'b0;
      fmt_len = '0;
      fmt_idx = '0;
      held = 1'b0;
      held_st = ST_OK;
      held_off = '0;
      held_frames = '0;
    endfunction

    function void settle(logic [3:0] st, logic [31:0] off, logic [31:0] frames);
      held = 1'b1;
      held_st = st;
      held_off = off;
      held_frames = frames;
      phase = PH_HOLD;
    endfunction

    function logic [3:0] fmt_status();
      if (mode != MODE_PCM && mode != MODE_FLOAT) return ST_MODE;
      if (ext != 0) return ST_EXT;
      if (chans != 1 && chans != 2) return ST_CHANNELS;
      if (bits != 8 && bits != 16 && bits != 24 && bits != 32 && bits != 64) return ST_BITS;
      if (bits == 24 && align != 16'(3 * chans)) return ST_ALIGN24;
      return ST_OK;
    endfunction

    function void fmt_byte(logic [7:0] b);
      int p;
      int k;
      logic [3:0] st;
      p = fmt_idx;
      k = p % 2;
      if (p < 2) mode[8*k +: 8] = b;
      else if (p < 4) chans[8*k +: 8] = b;
      else if (p < 8) rate[8*(p-4) +: 8] = b;
      else if (p < 12) ;
      else if (p < 14) align[8*k +: 8] = b;
      else if (p < 16) bits[8*k +: 8] = b;
      else ext[8*k +: 8] = b;
      fmt_idx = fmt_idx + 8'd1;
      if (fmt_idx >= fmt_len) begin
        st = fmt_status();
        if (st != ST_OK) begin
          settle(st, '0, '0);
        end else begin
          phase = PH_CID;
          word = '0;
          word_idx = '0;
        end
      end
    endfunction

    function void parse(logic [7:0] b);
      logic [31:0] w;
      if (phase == PH_FMT) begin
        fmt_byte(b);
        return;
      end
      if (phase == PH_SKIP) begin
        skip_left = skip_left - 1;
        if (skip_left == 0) phase = PH_CID;
        return;
      end
      if (phase == PH_HOLD) return;
      word = word | (32'(b) << (8 * word_idx[1:0]));
      word_idx = word_idx + 3'd1;
      if (word_idx < 4) return;
      w = word;
      word = '0;
      word_idx = '0;
      case (phase)
        PH_RIFF: begin
          if (w != TAG_RIFF) settle(ST_NOT_RIFF, '0, '0);
          else phase = PH_RSIZE;
        end
        PH_RSIZE: begin
          riff_sz = w;
          phase = PH_WAVE;
        end
        PH_WAVE: begin
          if (w != TAG_WAVE) settle(ST_NOT_WAVE, '0, '0);
          else phase = PH_CID;
        end
        PH_CID: begin
          kind = (w == TAG_FMT) ? KIND_FMT : ((w == TAG_DATA) ? KIND_DATA : KIND_OTHER);
          phase = PH_CSIZE;
        end
        default: begin
          if (kind == KIND_FMT) begin
            if (w != FMT_SHORT && w != FMT_LONG) begin
              settle(ST_FMT_SIZE, '0, '0);
            end else begin
              fmt_len = w[7:0];
              fmt_idx = '0;
              ext = '0;
              phase = PH_FMT;
            end
          end else if (kind == KIND_DATA) begin
            if (align == 0) settle(ST_ZERO_ALGN, '0, '0);
            else settle(ST_OK, seen, w / {16'd0, align});
          end else begin
            skip_left = w;
            phase = (w != 0) ? PH_SKIP : PH_CID;
          end
        end
      endcase
    endfunction

    function wav_verdict_t verdict(logic [3:0] st);
      wav_verdict_t v;
      v = '0;
      v.status = st;
      if (st != ST_OK) return v;
      v.channel_count = chans[1:0];
      v.rate_hz = rate[30:0];
      if (mode == MODE_FLOAT) begin
        v.in_format = (bits == 32) ? IF_F32 : IF_F64;
        v.out_format = OF_F32;
      end else begin
        case (bits)
          16'd24: begin
            v.in_format = IF_S24;
            v.out_format = OF_S16;
          end
          16'd8: begin
            v.in_format = IF_U8;
            v.out_format = OF_U8;
          end
          16'd16: begin
            v.in_format = IF_S16;
            v.out_format = OF_S16;
          end
          default: begin
            v.in_format = IF_S32;
            v.out_format = OF_S32;
          end
        endcase
      end
      v.riff_size = riff_sz;
      v.data_offset = held_off;
      v.frame_count = held_frames;
      return v;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      if (seen != '1) seen = seen + 1;
      if (!given) begin
        parse(b);
        if (held && seen >= MIN_STREAM) begin
          verdicts_due.push_back(verdict(held_st));
          given = 1'b1;
        end else if (last) begin
          verdicts_due.push_back(verdict((seen < MIN_STREAM) ? ST_SHORT : ST_NO_DATA));
        end
      end
      if (last) clear();
    endfunction

    function void field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_verdict(logic [RES_W-1:0] d);
      wav_verdict_t got;
      wav_verdict_t want;
      got = d;
      if (verdicts_due.size() == 0) begin
        $error("verdict %h arrived with none expected", d);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      field_ok("status", want.status, got.status);
      field_ok("channel_count", want.channel_count, got.channel_count);
      field_ok("rate_hz", want.rate_hz, got.rate_hz);
      field_ok("in_format", want.in_format, got.in_format);
      field_ok("out_format", want.out_format, got.out_format);
      field_ok("riff_size", want.riff_size, got.riff_size);
      field_ok("data_offset", want.data_offset, got.data_offset);
      field_ok("frame_count", want.frame_count, got.frame_count);
      field_ok("padding", want.pad, got.pad);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = '0;
  logic             in_tlast = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [RES_W-1:0] out_tdata;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic pressure_req = 1'b0;
  logic pressure_done = 1'b0;
  int hold_left = 0;
  int quiet = 0;

  wav_verdict_tracker board = new();

  wav_header_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (pressure_req && !pressure_done) begin
      pressure_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_verdict(out_tdata);
      if (in_tvalid && in_tready) board.note_byte(in_tdata, in_tlast);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic void push32(ref logic [7:0] q[$], input logic [31:0] w);
    for (int i = 0; i < 4; i++) q.push_back(w[8*i +: 8]);
  endfunction

  function automatic void push16(ref logic [7:0] q[$], input logic [15:0] w);
    q.push_back(w[7:0]);
    q.push_back(w[15:8]);
  endfunction

  function automatic void push_fmt(ref logic [7:0] q[$], input wav_spec_t s);
    push32(q, TAG_FMT);
    push32(q, s.fmt_len);
    push16(q, s.mode);
    push16(q, s.chans);
    push32(q, s.rate);
    push32(q, $urandom());
    push16(q, s.align);
    push16(q, s.bits);
    if (s.fmt_len == FMT_LONG) push16(q, s.ext);
  endfunction

  function automatic void build_wav(ref logic [7:0] q[$], input wav_spec_t s);
    wav_spec_t early;
    int n;
    q.delete();
    push32(q, s.riff_tag);
    push32(q, s.riff_size);
    push32(q, s.wave_tag);
    if (s.has_lead) begin
      push32(q, $urandom());
      push32(q, s.lead_len);
      n = (s.lead_len > 8) ? 8 : int'(s.lead_len);
      repeat (n) q.push_back(8'($urandom_range(255)));
    end
    if (s.has_fmt) begin
      if (s.fmt_twice) begin
        early = s;
        early.fmt_len = FMT_SHORT;
        early.mode = MODE_PCM;
        early.chans = 16'd2;
        early.rate = $urandom();
        early.align = 16'($urandom());
        early.bits = 16'd16;
        push_fmt(q, early);
      end
      push_fmt(q, s);
    end
    if (s.has_data) begin
      push32(q, TAG_DATA);
      push32(q, s.data_len);
    end
    repeat (s.payload) q.push_back(8'($urandom_range(255)));
    if (s.cut > 0 && s.cut < q.size()) q = q[0:s.cut-1];
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] pick_align();
    case ($urandom_range(15))
      0: return '0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return 16'd4;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_bits();
    case ($urandom_range(4))
      0: return 16'd8;
      1: return 16'd16;
      2: return 16'd24;
      3: return 16'd32;
      default: return 16'd64;
    endcase
  endfunction

  function automatic wav_spec_t base_spec();
    wav_spec_t s;
    s.riff_tag = TAG_RIFF;
    s.riff_size = $urandom();
    s.wave_tag = TAG_WAVE;
    s.has_lead = 1'b0;
    s.lead_len = '0;
    s.has_fmt = 1'b1;
    s.fmt_twice = 1'b0;
    s.fmt_len = FMT_SHORT;
    s.mode = MODE_PCM;
    s.chans = 16'd2;
    s.rate = $urandom();
    s.align = 16'd4;
    s.bits = 16'd16;
    s.ext = '0;
    s.has_data = 1'b1;
    s.data_len = $urandom();
    s.payload = 3;
    s.cut = 0;
    return s;
  endfunction

  function automatic wav_spec_t random_spec();
    wav_spec_t s;
    int r;
    r = $urandom_range(99);
    s = base_spec();
    if (r < 3) s.riff_tag = $urandom();
    else if (r < 6) s.wave_tag = $urandom();
    s.riff_size = pick32();
    s.has_lead = ($urandom_range(3) == 0);
    s.lead_len = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(6);
    s.has_fmt = ($urandom_range(19) != 0);
    s.fmt_twice = ($urandom_range(9) == 0);
    if ($urandom_range(19) == 0) s.fmt_len = $urandom_range(40);
    else s.fmt_len = $urandom_range(1) ? FMT_LONG : FMT_SHORT;
    if ($urandom_range(15) == 0) s.mode = 16'($urandom());
    else s.mode = $urandom_range(1) ? MODE_FLOAT : MODE_PCM;
    s.chans = ($urandom_range(15) == 0) ? 16'($urandom()) : 16'($urandom_range(2, 1));
    s.bits = ($urandom_range(15) == 0) ? 16'($urandom_range(80)) : pick_bits();
    s.rate = pick32();
    if (s.bits == 24 && $urandom_range(7) != 0) s.align = 16'(3 * s.chans);
    else s.align = pick_align();
    s.ext = ($urandom_range(15) == 0) ? 16'($urandom()) : 16'd0;
    s.has_data = ($urandom_range(19) != 0);
    s.data_len = pick32();
    s.payload = s.has_data ? $urandom_range(4) : $urandom_range(30);
    s.cut = ($urandom_range(9) == 0) ? $urandom_range(60, 1) : 0;
    return s;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_file(ref logic [7:0] q[$]);
    for (int i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
  endtask

  initial begin
    wav_spec_t spec;
    logic [7:0] file_q[$];
    int sent;
    int stage;
    sent = 0;
    stage = 0;
    send_idle_pct = 7;
    recv_idle_pct <= 57;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < 24; k++) begin
      spec = base_spec();
      case (k)
        0: begin
          spec.bits = 16'd8;
          spec.chans = 16'd1;
          spec.riff_size = '0;
          spec.rate = '0;
          spec.data_len = '0;
          spec.align = 16'd1;
        end
        1: begin
          spec.riff_size = '1;
          spec.rate = '1;
          spec.data_len = '1;
          spec.align = 16'hFFFF;
        end
        2: begin
          spec.bits = 16'd24;
          spec.align = 16'd6;
          spec.fmt_len = FMT_LONG;
        end
        3: spec.bits = 16'd32;
        4: spec.bits = 16'd64;
        5: begin
          spec.mode = MODE_FLOAT;
          spec.bits = 16'd32;
        end
        6: begin
          spec.mode = MODE_FLOAT;
          spec.bits = 16'd64;
        end
        7: begin
          spec.mode = MODE_FLOAT;
          spec.bits = 16'd16;
          spec.chans = 16'd1;
        end
        8: spec.riff_tag = TAG_WAVE;
        9: spec.wave_tag = TAG_RIFF;
        10: spec.fmt_len = 32'd20;
        11: spec.mode = 16'd2;
        12: begin
          spec.fmt_len = FMT_LONG;
          spec.ext = 16'd5;
        end
        13: spec.chans = 16'd3;
        14: spec.bits = 16'd12;
        15: begin
          spec.bits = 16'd24;
          spec.align = 16'd4;
        end
        16: begin
          spec.has_fmt = 1'b0;
          spec.payload = 30;
        end
        17: spec.align = '0;
        18: spec.cut = 30;
        19: begin
          spec.has_data = 1'b0;
          spec.payload = 10;
        end
        20: begin
          spec.has_lead = 1'b1;
          spec.lead_len = '0;
        end
        21: begin
          spec.has_lead = 1'b1;
          spec.lead_len = 32'hFFFF_FFF0;
        end
        22: spec.fmt_twice = 1'b1;
        default: spec.cut = 1;
      endcase
      build_wav(file_q, spec);
      send_file(file_q);
    end

    while (sent < RANDOM_BYTES) begin
      if (stage == 0 && sent >= RANDOM_BYTES / 3) begin
        stage = 1;
        send_idle_pct = 57;
        recv_idle_pct <= 7;
      end else if (stage == 1 && sent >= 2 * RANDOM_BYTES / 3) begin
        stage = 2;
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        pressure_req <= 1'b1;
      end
      if ($urandom_range(19) == 0) begin
        file_q.delete();
        repeat ($urandom_range(60, 1)) file_q.push_back(8'($urandom_range(255)));
      end else begin
        build_wav(file_q, random_spec());
      end
      send_file(file_q);
      sent += file_q.size();
    end
    in_tvalid <= 1'b0;

    repeat (2) @(posedge clk);
    while (board.verdicts_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/whp_pkg.sv
sv/whp_div.sv
sv/wav_header_parser.sv
sim/tb_top.sv
